[hdl/prd_pkg.sv]
// Shared constants, codes and types of the PCX run-length pixel decoder.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

   localparam int unsigned PRD_MAX_LINE_BYTES = 4096;

   localparam int unsigned PIX_W      = 8;
   localparam int unsigned PAL_W      = 3 * PIX_W;
   localparam int unsigned PAL_AW     = 8;
   localparam int unsigned LB_W       = 13;
   localparam int unsigned LB_MAX     = (2 ** LB_W) - 1;
   localparam int unsigned POS_W      = 15;
   localparam int unsigned COL_W      = 15;
   localparam int unsigned DIM_W      = 16;
   localparam int unsigned RUN_W      = 6;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_MONO    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RGB     = 2'd2;

   localparam logic OP_IMAGE   = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_VALID = 3'd4;

   localparam logic [PIX_W-1:0] RUN_MARK       = 8'hC0;
   localparam logic [PIX_W-1:0] RUN_COUNT_MASK = 8'h3F;
   localparam logic [PIX_W-1:0] MONO_FULL      = 8'hFF;
   localparam logic [CNT_W-1:0] MONO_GROUP     = 4'd8;

   // scanline limits derived from the configuration
   typedef struct packed {
      logic [LB_W-1:0]  line_len;
      logic [POS_W-1:0] plane2_start;
      logic [POS_W-1:0] scan_size;
      logic [POS_W-1:0] emit_lo;
      logic [POS_W-1:0] emit_hi;
   } prd_geom_type;

endpackage

`default_nettype wire

[hdl/prd_line_ram.sv]
// One-byte-wide scanline plane buffer with one write and one registered read port.
// Depends on prd_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

module prd_line_ram
   import prd_pkg::*;
#(
   parameter int unsigned DEPTH = PRD_MAX_LINE_BYTES,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [PIX_W-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/prd_palette_ram.sv]
// 256-entry palette store, {red, green, blue} per entry, registered read.
// Depends on prd_pkg for entry and address widths.
`timescale 1ns / 1ps
`default_nettype none

module prd_palette_ram
   import prd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [PAL_AW-1:0] wr_addr,
   input  wire logic [PAL_W-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [PAL_AW-1:0] rd_addr,
   output logic      [PAL_W-1:0]  rd_data
);

   logic [PAL_W-1:0] mem [2 ** PAL_AW];
   logic [PAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/prd_geometry.sv]
// Registered scanline limits: clamped line length, scanline size, emitting window.
// Depends on prd_pkg for widths, mode codes and prd_geom_type.
`timescale 1ns / 1ps
`default_nettype none

module prd_geometry
   import prd_pkg::*;
#(
   parameter int unsigned MAX_LINE_BYTES = PRD_MAX_LINE_BYTES
) (
   input  wire logic              clock,
   input  wire logic [MODE_W-1:0] pixel_mode,
   input  wire logic [LB_W-1:0]   line_bytes,
   input  wire logic [DIM_W-1:0]  image_width,
   output prd_geom_type           geom
);

   localparam int unsigned CAP_I = (MAX_LINE_BYTES >= LB_MAX) ? LB_MAX : MAX_LINE_BYTES;
   localparam logic [LB_W-1:0] LB_CAP = LB_W'(CAP_I);

   prd_geom_type     geom_ff;
   prd_geom_type     geom_in;
   logic [LB_W-1:0]  lb;
   logic [POS_W-1:0] lb_p;
   logic [POS_W-1:0] lb2;
   logic [POS_W-1:0] lb3;
   logic [DIM_W:0]   w_round;
   logic [POS_W-1:0] mono_lim;
   logic [POS_W-1:0] mono_hi;
   logic [POS_W-1:0] idx_hi;
   logic [DIM_W:0]   rgb_end;
   logic [POS_W-1:0] rgb_hi;

   always_comb begin
      if (line_bytes == '0) begin
         lb = LB_W'(1);
      end else if (line_bytes > LB_CAP) begin
         lb = LB_CAP;
      end else begin
         lb = line_bytes;
      end
      lb_p     = POS_W'(lb);
      lb2      = {lb_p[POS_W-2:0], 1'b0};
      lb3      = lb2 + lb_p;
      w_round  = {1'b0, image_width} + (DIM_W + 1)'(7);
      mono_lim = POS_W'(w_round >> 3);
      mono_hi  = (mono_lim < lb_p) ? mono_lim : lb_p;
      idx_hi   = (image_width < DIM_W'(lb)) ? POS_W'(image_width) : lb_p;
      rgb_end  = (DIM_W + 1)'(lb2) + {1'b0, image_width};
      rgb_hi   = (rgb_end < (DIM_W + 1)'(lb3)) ? POS_W'(rgb_end) : lb3;

      geom_in.line_len     = lb;
      geom_in.plane2_start = lb2;
      unique case (pixel_mode)
         MODE_MONO: begin
            geom_in.scan_size = lb_p;
            geom_in.emit_lo   = '0;
            geom_in.emit_hi   = mono_hi;
         end
         MODE_INDEXED: begin
            geom_in.scan_size = lb_p;
            geom_in.emit_lo   = '0;
            geom_in.emit_hi   = idx_hi;
         end
         MODE_RGB: begin
            geom_in.scan_size = lb3;
            geom_in.emit_lo   = lb2;
            geom_in.emit_hi   = rgb_hi;
         end
         default: begin
            geom_in.scan_size = lb_p;
            geom_in.emit_lo   = '0;
            geom_in.emit_hi   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

`default_nettype wire

[hdl/pcx_rle_pixel_decoder_unit.sv]
// PCX run-length pixel decoder, top level: configuration registers, run sequencer,
// placement step, memory read stage and result register.
// Depends on prd_pkg, prd_geometry, prd_line_ram and prd_palette_ram.
// A first result passes the sequencer, read stage and result register in turn.
// A literal byte is placed once, a run value byte up to n times for a run count n,
// one placement per cycle through the shared position/limit step unless stalled.
// Reset: synchronous, clears sequencer, run and line state; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_pixel_decoder_unit
   import prd_pkg::*;
#(
   parameter int unsigned MAX_LINE_BYTES = PRD_MAX_LINE_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [PIX_W-1:0]      req_data_byte,
   input  wire logic [PAL_AW-1:0]     req_palette_index,
   input  wire logic [PIX_W-1:0]      req_palette_red,
   input  wire logic [PIX_W-1:0]      req_palette_green,
   input  wire logic [PIX_W-1:0]      req_palette_blue,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [PIX_W-1:0]      rsp_pixel_blue,
   output logic      [PIX_W-1:0]      rsp_pixel_green,
   output logic      [PIX_W-1:0]      rsp_pixel_red,
   output logic      [PIX_W-1:0]      rsp_mono_bits,
   output logic      [CNT_W-1:0]      rsp_pixel_count,
   output logic      [COL_W-1:0]      rsp_column,
   output logic      [DIM_W-1:0]      rsp_row,
   output logic                       rsp_last,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int unsigned LINE_AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PLACE = 1'b1;

   // configuration
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [LB_W-1:0]   line_bytes_ff, line_bytes_in;
   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic              pal_valid_ff, pal_valid_in;

   // sequencer
   logic              state_ff, state_in;
   logic [RUN_W-1:0]  rem_ff, rem_in;
   logic [PIX_W-1:0]  value_ff, value_in;
   logic              pend_ff, pend_in;
   logic [RUN_W-1:0]  run_len_ff, run_len_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DIM_W-1:0]  row_ff, row_in;

   // placement step
   prd_geom_type      geom;
   logic              accept;
   logic              step;
   logic [POS_W-1:0]  p_inc;
   logic              at_end;
   logic              do_emit;
   logic              in_plane1;
   logic              in_plane2;
   logic [POS_W-1:0]  lb_p;
   logic [POS_W-1:0]  x_pos;
   logic [POS_W+2:0]  pix_x;
   logic [POS_W+2:0]  mono_left;
   logic [CNT_W-1:0]  mono_cnt;
   logic [PIX_W-1:0]  mono_keep;
   logic              red_we;
   logic              green_we;
   logic              line_rd;
   logic              pal_rd;

   // memory read stage
   logic              out_free;
   logic              mid_go;
   logic              mid_free;
   logic              mid_valid_ff, mid_valid_in;
   logic [MODE_W-1:0] mid_mode_ff, mid_mode_in;
   logic              mid_pal_ff, mid_pal_in;
   logic [PIX_W-1:0]  mid_value_ff, mid_value_in;
   logic [PIX_W-1:0]  mid_mono_ff, mid_mono_in;
   logic [CNT_W-1:0]  mid_cnt_ff, mid_cnt_in;
   logic [COL_W-1:0]  mid_col_ff, mid_col_in;
   logic [DIM_W-1:0]  mid_row_ff, mid_row_in;
   logic              mid_last_ff, mid_last_in;
   logic [PIX_W-1:0]  red_rd;
   logic [PIX_W-1:0]  green_rd;
   logic [PAL_W-1:0]  pal_entry;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  out_blue_ff, out_blue_in;
   logic [PIX_W-1:0]  out_green_ff, out_green_in;
   logic [PIX_W-1:0]  out_red_ff, out_red_in;
   logic [PIX_W-1:0]  out_mono_ff;
   logic [CNT_W-1:0]  out_cnt_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [DIM_W-1:0]  out_row_ff;
   logic              out_last_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // configuration writes
   always_comb begin
      mode_in       = mode_ff;
      line_bytes_in = line_bytes_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      pal_valid_in  = pal_valid_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PIXEL_MODE:    mode_in       = csr_write_data[MODE_W-1:0];
            CSR_LINE_BYTES:    line_bytes_in = csr_write_data[LB_W-1:0];
            CSR_IMAGE_WIDTH:   width_in      = csr_write_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  height_in     = csr_write_data[DIM_W-1:0];
            CSR_PALETTE_VALID: pal_valid_in  = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_INDEXED;
         line_bytes_ff <= LB_W'(1);
         width_ff      <= DIM_W'(1);
         height_ff     <= DIM_W'(1);
         pal_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         line_bytes_ff <= line_bytes_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         pal_valid_ff  <= pal_valid_in;
      end
   end

   prd_geometry #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES)
   ) u_geometry (
      .clock       (clock),
      .pixel_mode  (mode_ff),
      .line_bytes  (line_bytes_ff),
      .image_width (width_ff),
      .geom        (geom)
   );

   // placement step
   assign out_free = !out_valid_ff || rsp_ready;
   assign mid_go   = mid_valid_ff && out_free;
   assign mid_free = !mid_valid_ff || out_free;
   assign step     = (state_ff == ST_PLACE) && mid_free;

   always_comb begin
      p_inc     = pos_ff + POS_W'(1);
      at_end    = (p_inc >= geom.scan_size);
      do_emit   = (pos_ff >= geom.emit_lo) && (pos_ff < geom.emit_hi);
      lb_p      = POS_W'(geom.line_len);
      in_plane1 = (pos_ff >= lb_p);
      in_plane2 = (pos_ff >= geom.plane2_start);
      if (in_plane2) begin
         x_pos = pos_ff - geom.plane2_start;
      end else if (in_plane1) begin
         x_pos = pos_ff - lb_p;
      end else begin
         x_pos = pos_ff;
      end
      pix_x     = {pos_ff, 3'b000};
      mono_left = (POS_W + 3)'(width_ff) - pix_x;
      mono_cnt  = (mono_left >= (POS_W + 3)'(MONO_GROUP)) ? MONO_GROUP : mono_left[CNT_W-1:0];
      mono_keep = ~(MONO_FULL >> mono_cnt);

      red_we   = step && (mode_ff == MODE_RGB) && !in_plane1;
      green_we = step && (mode_ff == MODE_RGB) && in_plane1 && !in_plane2;
      line_rd  = step && do_emit && (mode_ff == MODE_RGB);
      pal_rd   = step && do_emit && (mode_ff == MODE_INDEXED) && pal_valid_ff;

      mid_mode_in  = mode_ff;
      mid_pal_in   = pal_valid_ff;
      mid_value_in = value_ff;
      mid_row_in   = row_ff;
      mid_last_in  = (p_inc >= geom.emit_hi) || (rem_ff == RUN_W'(1));
      if (mode_ff == MODE_MONO) begin
         mid_mono_in = value_ff & mono_keep;
         mid_cnt_in  = mono_cnt;
      end else begin
         mid_mono_in = '0;
         mid_cnt_in  = CNT_W'(1);
      end
      unique case (mode_ff)
         MODE_MONO:    mid_col_in = COL_W'(pix_x);
         MODE_INDEXED: mid_col_in = COL_W'(pos_ff);
         default:      mid_col_in = COL_W'(x_pos);
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      value_in   = value_ff;
      pend_in    = pend_ff;
      run_len_in = run_len_ff;
      pos_in     = pos_ff;
      row_in     = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_IMAGE) && (row_ff < height_ff)) begin
               if (pend_ff) begin
                  pend_in    = 1'b0;
                  run_len_in = '0;
                  if (run_len_ff != '0) begin
                     state_in = ST_PLACE;
                     rem_in   = run_len_ff;
                     value_in = req_data_byte;
                  end
               end else if ((req_data_byte & RUN_MARK) == RUN_MARK) begin
                  pend_in    = 1'b1;
                  run_len_in = RUN_W'(req_data_byte & RUN_COUNT_MASK);
               end else begin
                  state_in = ST_PLACE;
                  rem_in   = RUN_W'(1);
                  value_in = req_data_byte;
               end
            end
         end
         ST_PLACE: begin
            if (step) begin
               rem_in = rem_ff - RUN_W'(1);
               if (at_end) begin
                  pos_in = '0;
                  row_in = row_ff + DIM_W'(1);
               end else begin
                  pos_in = p_inc;
               end
               if (at_end || (rem_ff == RUN_W'(1))) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rem_ff     <= '0;
         pend_ff    <= 1'b0;
         run_len_ff <= '0;
         pos_ff     <= '0;
         row_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rem_ff     <= rem_in;
         pend_ff    <= pend_in;
         run_len_ff <= run_len_in;
         pos_ff     <= pos_in;
         row_ff     <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // memories
   prd_line_ram #(
      .DEPTH (MAX_LINE_BYTES),
      .AW    (LINE_AW)
   ) u_red_line (
      .clock   (clock),
      .wr_en   (red_we),
      .wr_addr (LINE_AW'(x_pos)),
      .wr_data (value_ff),
      .rd_en   (line_rd),
      .rd_addr (LINE_AW'(x_pos)),
      .rd_data (red_rd)
   );

   prd_line_ram #(
      .DEPTH (MAX_LINE_BYTES),
      .AW    (LINE_AW)
   ) u_green_line (
      .clock   (clock),
      .wr_en   (green_we),
      .wr_addr (LINE_AW'(x_pos)),
      .wr_data (value_ff),
      .rd_en   (line_rd),
      .rd_addr (LINE_AW'(x_pos)),
      .rd_data (green_rd)
   );

   prd_palette_ram u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_operation == OP_PALETTE)),
      .wr_addr (req_palette_index),
      .wr_data ({req_palette_red, req_palette_green, req_palette_blue}),
      .rd_en   (pal_rd),
      .rd_addr (value_ff),
      .rd_data (pal_entry)
   );

   // memory read stage
   always_comb begin
      if (step && do_emit) begin
         mid_valid_in = 1'b1;
      end else if (mid_go) begin
         mid_valid_in = 1'b0;
      end else begin
         mid_valid_in = mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && do_emit) begin
         mid_mode_ff  <= mid_mode_in;
         mid_pal_ff   <= mid_pal_in;
         mid_value_ff <= mid_value_in;
         mid_mono_ff  <= mid_mono_in;
         mid_cnt_ff   <= mid_cnt_in;
         mid_col_ff   <= mid_col_in;
         mid_row_ff   <= mid_row_in;
         mid_last_ff  <= mid_last_in;
      end
   end

   // result register
   always_comb begin
      unique case (mid_mode_ff)
         MODE_INDEXED: begin
            if (mid_pal_ff) begin
               out_blue_in  = pal_entry[PIX_W-1:0];
               out_green_in = pal_entry[2*PIX_W-1:PIX_W];
               out_red_in   = pal_entry[PAL_W-1:2*PIX_W];
            end else begin
               out_blue_in  = mid_value_ff;
               out_green_in = mid_value_ff;
               out_red_in   = mid_value_ff;
            end
         end
         MODE_RGB: begin
            out_blue_in  = mid_value_ff;
            out_green_in = green_rd;
            out_red_in   = red_rd;
         end
         default: begin
            out_blue_in  = '0;
            out_green_in = '0;
            out_red_in   = '0;
         end
      endcase

      if (mid_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_go) begin
         out_blue_ff  <= out_blue_in;
         out_green_ff <= out_green_in;
         out_red_ff   <= out_red_in;
         out_mono_ff  <= mid_mono_ff;
         out_cnt_ff   <= mid_cnt_ff;
         out_col_ff   <= mid_col_ff;
         out_row_ff   <= mid_row_ff;
         out_last_ff  <= mid_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_blue  = out_blue_ff;
   assign rsp_pixel_green = out_green_ff;
   assign rsp_pixel_red   = out_red_ff;
   assign rsp_mono_bits   = out_mono_ff;
   assign rsp_pixel_count = out_cnt_ff;
   assign rsp_column      = out_col_ff;
   assign rsp_row         = out_row_ff;
   assign rsp_last        = out_last_ff;

   // checks
   a_place_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> (rem_ff != '0))
      else $error("placement active with no bytes left");

   a_row_held_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(row_ff))
      else $error("row counter moved outside placement");

   a_no_mid_overrun: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !out_free) |=> (mid_valid_ff && $stable(mid_col_ff)))
      else $error("read stage transaction lost while result stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pixel_count != '0) && (rsp_pixel_count <= MONO_GROUP)))
      else $error("pixel count out of range");

endmodule

`default_nettype wire

[dv/prd_pixel_checker.sv]
// Result checker of the PCX run-length pixel decoder: watches the CSR port and both
// channels, keeps its own decoder state and compares every pixel result in order.
// Depends on prd_pkg for widths, modes, opcodes and CSR indexes.
`timescale 1ns / 1ps

module prd_pixel_checker
   import prd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic                  req_operation,
   input  wire logic [PIX_W-1:0]      req_data_byte,
   input  wire logic [PAL_AW-1:0]     req_palette_index,
   input  wire logic [PIX_W-1:0]      req_palette_red,
   input  wire logic [PIX_W-1:0]      req_palette_green,
   input  wire logic [PIX_W-1:0]      req_palette_blue,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [PIX_W-1:0]      rsp_pixel_blue,
   input  wire logic [PIX_W-1:0]      rsp_pixel_green,
   input  wire logic [PIX_W-1:0]      rsp_pixel_red,
   input  wire logic [PIX_W-1:0]      rsp_mono_bits,
   input  wire logic [CNT_W-1:0]      rsp_pixel_count,
   input  wire logic [COL_W-1:0]      rsp_column,
   input  wire logic [DIM_W-1:0]      rsp_row,
   input  wire logic                  rsp_last,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output int unsigned                mismatch_count,
   output int unsigned                results_pending,
   output int unsigned                line_now,
   output logic [DIM_W-1:0]           row_now
);

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] mono;
      logic [CNT_W-1:0] count;
      logic [COL_W-1:0] column;
      logic [DIM_W-1:0] row;
      logic             last;
   } pixel_beat_t;

   pixel_beat_t expected_pixels[$];

   logic [MODE_W-1:0] pixel_mode;
   logic [LB_W-1:0]   line_bytes;
   logic [DIM_W-1:0]  image_width;
   logic [DIM_W-1:0]  image_height;
   logic              palette_valid;

   logic              run_pending;
   logic [RUN_W-1:0]  run_length;
   int unsigned       line_pos;
   logic [DIM_W-1:0]  row_count;
   logic [PIX_W-1:0]  red_mem [PRD_MAX_LINE_BYTES];
   logic [PIX_W-1:0]  green_mem [PRD_MAX_LINE_BYTES];
   logic [PAL_W-1:0]  palette_mem [256];

   initial begin
      mismatch_count = 0;
      results_pending = 0;
      line_now = 0;
      row_now = '0;
   end

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // place one decoded byte on the scanline; closed flags the end of the line
   task automatic place_byte(input logic [PIX_W-1:0] v, output bit closed, output bit made,
                             output pixel_beat_t px);
      int unsigned lb, span, p, x, cnt, plane;
      logic [PIX_W-1:0] keep;
      logic [PAL_W-1:0] entry;
      lb = line_bytes;
      if (lb == 0) lb = 1;
      if (lb > PRD_MAX_LINE_BYTES) lb = PRD_MAX_LINE_BYTES;
      span = (pixel_mode == MODE_RGB) ? 3 * lb : lb;
      p = line_pos;
      made = 1'b0;
      px = '0;
      px.row = row_count;
      px.count = 1;
      if (p < span) begin
         case (pixel_mode)
            MODE_MONO: begin
               x = p * 8;
               if (x < image_width) begin
                  cnt = image_width - x;
                  if (cnt > MONO_GROUP) cnt = MONO_GROUP;
                  keep = MONO_FULL << (8 - cnt);
                  px.mono = v & keep;
                  px.count = cnt[CNT_W-1:0];
                  px.column = x[COL_W-1:0];
                  made = 1'b1;
               end
            end
            MODE_INDEXED: begin
               if (p < image_width) begin
                  entry = palette_valid ? palette_mem[v] : {v, v, v};
                  px.red = entry[3*PIX_W-1:2*PIX_W];
                  px.green = entry[2*PIX_W-1:PIX_W];
                  px.blue = entry[PIX_W-1:0];
                  px.column = p[COL_W-1:0];
                  made = 1'b1;
               end
            end
            MODE_RGB: begin
               plane = p / lb;
               x = p % lb;
               if (plane == 0) begin
                  red_mem[x] = v;
               end else if (plane == 1) begin
                  green_mem[x] = v;
               end else if (x < image_width) begin
                  px.blue = v;
                  px.green = green_mem[x];
                  px.red = red_mem[x];
                  px.column = x[COL_W-1:0];
                  made = 1'b1;
               end
            end
            default: ;
         endcase
      end
      closed = (p + 1 >= span);
      if (closed) begin
         line_pos = 0;
         row_count = row_count + 1'b1;
      end else begin
         line_pos = p + 1;
      end
   endtask

   task automatic decode_request(input logic op, input logic [PIX_W-1:0] data,
                                 input logic [PAL_AW-1:0] idx,
                                 input logic [PIX_W-1:0] r, g, b);
      pixel_beat_t px, held;
      bit closed, made, holding;
      int unsigned i, reps;
      holding = 1'b0;
      held = '0;
      reps = 0;
      if (op == OP_PALETTE) begin
         palette_mem[idx] = {r, g, b};
      end else if (row_count < image_height) begin
         if (run_pending) begin
            reps = run_length;
            run_pending = 1'b0;
            run_length = '0;
         end else if ((data & RUN_MARK) == RUN_MARK) begin
            run_pending = 1'b1;
            run_length = data[RUN_W-1:0] & RUN_COUNT_MASK[RUN_W-1:0];
         end else begin
            reps = 1;
         end
         for (i = 0; i < reps; i++) begin
            place_byte(data, closed, made, px);
            if (made) begin
               if (holding) expected_pixels.push_back(held);
               held = px;
               holding = 1'b1;
            end
            if (closed) break;
         end
      end
      if (holding) begin
         held.last = 1'b1;
         expected_pixels.push_back(held);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_beat_t want;
      if (reset) begin
         pixel_mode = MODE_INDEXED;
         line_bytes = 1;
         image_width = 1;
         image_height = 1;
         palette_valid = 1'b0;
         run_pending = 1'b0;
         run_length = '0;
         line_pos = 0;
         row_count = '0;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PIXEL_MODE:    pixel_mode = csr_write_data[MODE_W-1:0];
               CSR_LINE_BYTES:    line_bytes = csr_write_data[LB_W-1:0];
               CSR_IMAGE_WIDTH:   image_width = csr_write_data;
               CSR_IMAGE_HEIGHT:  image_height = csr_write_data;
               CSR_PALETTE_VALID: palette_valid = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            decode_request(req_operation, req_data_byte, req_palette_index,
                           req_palette_red, req_palette_green, req_palette_blue);
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report("result with nothing expected, row", rsp_row, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_blue !== want.blue) report("pixel_blue", rsp_pixel_blue, want.blue);
               if (rsp_pixel_green !== want.green)
                  report("pixel_green", rsp_pixel_green, want.green);
               if (rsp_pixel_red !== want.red) report("pixel_red", rsp_pixel_red, want.red);
               if (rsp_mono_bits !== want.mono) report("mono_bits", rsp_mono_bits, want.mono);
               if (rsp_pixel_count !== want.count)
                  report("pixel_count", rsp_pixel_count, want.count);
               if (rsp_column !== want.column) report("column", rsp_column, want.column);
               if (rsp_row !== want.row) report("row", rsp_row, want.row);
               if (rsp_last !== want.last) report("last", rsp_last, want.last);
            end
         end
      end
      results_pending = expected_pixels.size();
      line_now = line_pos;
      row_now = row_count;
   end

endmodule

[dv/testbench.sv]
// Testbench top of the PCX run-length pixel decoder: clock, reset, CSR setup, byte and
// palette stimulus with random idling on both channels, and the final verdict.
// Depends on prd_pkg, pcx_rle_pixel_decoder_unit and prd_pixel_checker.
`timescale 1ns / 1ps

module testbench;
   import prd_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_operation;
   logic [PIX_W-1:0]      req_data_byte;
   logic [PAL_AW-1:0]     req_palette_index;
   logic [PIX_W-1:0]      req_palette_red;
   logic [PIX_W-1:0]      req_palette_green;
   logic [PIX_W-1:0]      req_palette_blue;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIX_W-1:0]      rsp_pixel_blue;
   logic [PIX_W-1:0]      rsp_pixel_green;
   logic [PIX_W-1:0]      rsp_pixel_red;
   logic [PIX_W-1:0]      rsp_mono_bits;
   logic [CNT_W-1:0]      rsp_pixel_count;
   logic [COL_W-1:0]      rsp_column;
   logic [DIM_W-1:0]      rsp_row;
   logic                  rsp_last;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int unsigned      mismatch_count;
   int unsigned      results_pending;
   int unsigned      line_now;
   logic [DIM_W-1:0] row_now;

   bit          calm;
   int unsigned cur_height;
   int unsigned live_items;

   pcx_rle_pixel_decoder_unit u_dut (.*);
   prd_pixel_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int unsigned pick_gap();
      return $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
   endfunction

   // enter at a falling edge, leave at the falling edge after the transaction
   task automatic send_req(input logic op, input logic [PIX_W-1:0] data,
                           input logic [PAL_AW-1:0] idx, input logic [PIX_W-1:0] r, g, b);
      int unsigned gap;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_palette_index <= idx;
      req_palette_red <= r;
      req_palette_green <= g;
      req_palette_blue <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [PIX_W-1:0] data);
      if (row_now < cur_height) live_items++;
      send_req(OP_IMAGE, data, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic send_palette(input logic [PAL_AW-1:0] idx, input logic [PIX_W-1:0] r, g, b);
      live_items++;
      send_req(OP_PALETTE, $urandom, idx, r, g, b);
   endtask

   // drain all results, then give the block time to finish silent placements
   task automatic settle();
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data[CSR_DATA_W-1:0];
      @(negedge clock);
   endtask

   task automatic configure(input logic [MODE_W-1:0] mode, input int unsigned lb, w, h,
                            input bit pv);
      settle();
      csr_put(CSR_PIXEL_MODE, mode);
      csr_put(CSR_LINE_BYTES, lb);
      csr_put(CSR_IMAGE_WIDTH, w);
      csr_put(CSR_IMAGE_HEIGHT, h);
      csr_put(CSR_PALETTE_VALID, pv);
      csr_write_enable <= 1'b0;
      cur_height = h & 16'hFFFF;
   endtask

   // bring the scanline back to its start so RGB planes are filled before use
   task automatic align_line();
      if (line_now != 0) begin
         configure(MODE_INDEXED, 1, 1, 16'hFFFF, 1'b0);
         while (line_now != 0) send_byte(8'h00);
      end
   endtask

   initial begin : drain
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = calm ? 0 : pick_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned k, n, lb, lbe, w, h, start;
      logic [MODE_W-1:0] mode;
      logic [RUN_W-1:0] len;
      bit pv;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_IMAGE;
      req_data_byte = '0;
      req_palette_index = '0;
      req_palette_red = '0;
      req_palette_green = '0;
      req_palette_blue = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PIXEL_MODE;
      csr_write_data = '0;
      calm = 1'b0;
      cur_height = 1;
      live_items = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole palette so indexed lookups never hit an empty entry
      for (int i = 0; i < 256; i++) begin
         if (i == 0) send_palette(i, 8'h00, 8'h00, 8'h00);
         else if (i == 255) send_palette(i, 8'hFF, 8'hFF, 8'hFF);
         else send_palette(i, $urandom, $urandom, $urandom);
      end

      // one-row image: the second byte and the run mark fall after the last row
      configure(MODE_INDEXED, 1, 1, 1, 1'b0);
      send_byte(8'h00);
      send_byte(8'hBF);
      send_byte(8'hFF);

      // run cut at line end, zero-length run, palette update between pixels
      configure(MODE_INDEXED, 4, 3, row_now + 4, 1'b1);
      send_byte(8'hC5);
      send_byte(8'hFF);
      send_byte(8'hC0);
      send_byte(8'h12);
      send_byte(8'h7F);
      send_palette(8'h7F, $urandom, $urandom, $urandom);
      send_byte(8'h7F);

      // shorter line leaves the position past the end: first byte closes the line
      configure(MODE_MONO, 2, 12, row_now + 4, 1'b0);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'hC3);
      send_byte(8'hFF);

      configure(MODE_UNUSED, 0, 32768, row_now + 2, 1'b0);
      send_byte(8'h33);

      align_line();
      configure(MODE_RGB, 2, 2, row_now + 3, 1'b1);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'hC2);
      send_byte(8'h33);
      send_byte(8'h44);
      send_byte(8'h55);

      start = live_items;
      while (live_items - start < 260) begin
         k = $urandom_range(0, 15);
         if (k < 5) mode = MODE_MONO;
         else if (k < 10) mode = MODE_INDEXED;
         else if (k < 15) mode = MODE_RGB;
         else mode = MODE_UNUSED;
         k = $urandom_range(0, 15);
         if (k == 0) lb = 0;
         else if (k == 1) lb = LB_MAX;
         else if (k == 2) lb = PRD_MAX_LINE_BYTES;
         else lb = $urandom_range(1, 12);
         lbe = (lb == 0) ? 1 : ((lb > 12) ? 12 : lb);
         k = $urandom_range(0, 15);
         if (k == 0) w = 32768;
         else if (k == 1) w = 0;
         else if (k == 2) w = 1;
         else w = $urandom_range(1, ((mode == MODE_MONO) ? 8 : 1) * lbe + 3);
         pv = $urandom_range(0, 1);
         if (mode == MODE_RGB) align_line();
         k = $urandom_range(0, 15);
         if (k == 0) h = row_now;
         else if (k == 1) h = 16'hFFFF;
         else h = row_now + $urandom_range(1, 8);
         if (h > 16'hFFFF) h = 16'hFFFF;
         configure(mode, lb, w, h, pv);
         calm = ($urandom_range(0, 3) == 0);
         n = $urandom_range(8, 40);
         repeat (n) begin
            k = $urandom_range(0, 19);
            if (k < 2) begin
               send_palette($urandom, $urandom, $urandom, $urandom);
            end else if (k < 4) begin
               send_byte($urandom);
            end else if (k < 12) begin
               send_byte($urandom_range(0, 8'hBF));
            end else begin
               len = ($urandom_range(0, 9) == 0) ? '0 : $urandom_range(1, 63);
               send_byte(RUN_MARK | {2'b00, len});
               send_byte($urandom);
            end
         end
         calm = 1'b0;
      end

      settle();
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
